>>> rtl/ra_pkg.sv
// shared types and constants of the room allocator
package ra_pkg;

	localparam int TIME_W        = 32;
	localparam int FINISH_W      = 48;
	localparam int USES_W        = 16;
	localparam int ROOM_W        = 4;
	localparam int CFG_W         = 5;
	// slot index width, wide enough for the largest room count supported
	localparam int SLOT_W        = 6;
	localparam int MAX_ROOMS_DEF = 16;

	localparam logic [CFG_W-1:0] NUM_ROOMS_RST = CFG_W'(16);

	typedef enum logic {
		MODE_SCAN,
		MODE_BUSY
	} scan_mode_t;

	// token handed from cell to cell along the chain
	typedef struct packed {
		logic                valid;
		scan_mode_t          mode;
		logic                found;
		logic [SLOT_W-1:0]   pick;
		logic [SLOT_W-1:0]   earliest;
		logic [FINISH_W-1:0] efin;
		logic [USES_W-1:0]   best_uses;
		logic [SLOT_W-1:0]   busiest;
	} scan_t;

	// write and clear broadcast to all cells
	typedef struct packed {
		logic                wr;
		logic                clr;
		logic [SLOT_W-1:0]   slot;
		logic [FINISH_W-1:0] finish;
	} upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_BUSY,
		ST_OUT
	} state_t;

endpackage

>>> rtl/ra_ifs.sv
// request, result and configuration channels of the room allocator
interface ra_req_if;
	logic                       valid;
	logic                       ready;
	logic [ra_pkg::TIME_W-1:0]  start_time;
	logic [ra_pkg::TIME_W-1:0]  end_time;
	logic                       last_request;

	modport source (output valid, start_time, end_time, last_request, input ready);
	modport sink   (input valid, start_time, end_time, last_request, output ready);
endinterface

interface ra_res_if;
	logic                        valid;
	logic                        ready;
	logic [ra_pkg::ROOM_W-1:0]   room;
	logic [ra_pkg::FINISH_W-1:0] finish_time;
	logic                        was_delayed;
	logic [ra_pkg::ROOM_W-1:0]   busiest_room;
	logic                        is_last;

	modport source (output valid, room, finish_time, was_delayed, busiest_room, is_last,
		input ready);
	modport sink   (input valid, room, finish_time, was_delayed, busiest_room, is_last,
		output ready);
endinterface

interface ra_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [ra_pkg::CFG_W-1:0]  num_rooms;

	modport source (output valid, num_rooms, input ready);
	modport sink   (input valid, num_rooms, output ready);
endinterface

>>> rtl/room_allocator_with_delay.sv
// top level of the room allocator: controller and chain of room cells
//
// Schedules requests (start_time, end_time), sent in nondecreasing start order, onto up to
// num_rooms rooms. Each room is a cell in a chain; a token carrying the scan state walks
// the chain one cell a cycle. The token is launched at the accepting edge and passes all
// MAX_ROOMS cells whatever num_rooms is; the room is committed when it reaches the tail, the
// result is loaded after that, and the next request can be accepted after the load. A
// request marked last_request sends a second token down the chain to find the busiest room
// after its own update; as its result is loaded all rooms clear and a new set begins.
// Beyond the chain length, only a result that still waits downstream when the next one is
// ready to load holds the flow back.
// A new request is taken only when the previous one has left the chain; the result register
// lets it be taken while the previous result still waits downstream. num_rooms of 0 acts as
// 1 and values above MAX_ROOMS act as MAX_ROOMS; it is to be written only while idle.
module room_allocator_with_delay #(
	parameter int MAX_ROOMS = ra_pkg::MAX_ROOMS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ra_req_if.sink    req,
	ra_res_if.source  res,
	ra_cfg_if.sink    cfg
);

	localparam int CNT_W = $clog2(MAX_ROOMS + 1);

	// controller state
	ra_pkg::state_t state_q;
	ra_pkg::state_t state_d;

	// request held for the whole scan
	logic [ra_pkg::TIME_W-1:0]   start_q;
	logic [ra_pkg::TIME_W-1:0]   end_q;
	logic [ra_pkg::TIME_W-1:0]   dur_q;
	logic                        last_q;

	// scan outcome
	logic [ra_pkg::SLOT_W-1:0]   pick_q;
	logic [ra_pkg::FINISH_W-1:0] fin_q;
	logic                        dly_q;
	logic [ra_pkg::SLOT_W-1:0]   busiest_q;

	// result register
	logic                        out_valid_q;
	logic [ra_pkg::ROOM_W-1:0]   res_room_q;
	logic [ra_pkg::FINISH_W-1:0] res_fin_q;
	logic                        res_dly_q;
	logic [ra_pkg::ROOM_W-1:0]   res_busy_q;
	logic                        res_last_q;

	logic [ra_pkg::CFG_W-1:0]    num_rooms_q;
	logic [CNT_W-1:0]            n_active;
	logic [MAX_ROOMS-1:0]        active;

	// chain links: link[0] is the injected token, link[MAX_ROOMS] the tail
	ra_pkg::scan_t               head_d;
	ra_pkg::scan_t               head_q;
	ra_pkg::scan_t               link [MAX_ROOMS+1];
	ra_pkg::scan_t               tail;
	logic [MAX_ROOMS:0]          tok_v;
	ra_pkg::upd_t                upd;

	// control strobes from the state machine
	logic                        req_ready;
	logic                        launch_scan;
	logic                        launch_busy;
	logic                        take_scan;
	logic                        load_out;
	logic                        out_free;

	// finish time arithmetic for the update cycle
	logic [ra_pkg::FINISH_W:0]   sum;
	logic [ra_pkg::FINISH_W-1:0] fin_calc;
	logic [ra_pkg::SLOT_W-1:0]   pick_calc;

	// configuration register, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rooms_q <= ra_pkg::NUM_ROOMS_RST;
		end else if (cfg.valid) begin
			num_rooms_q <= cfg.num_rooms;
		end
	end

	// clamp the room count into 1 .. MAX_ROOMS
	always_comb begin
		priority if (num_rooms_q == '0) begin
			n_active = CNT_W'(1);
		end else if (32'(num_rooms_q) > 32'(MAX_ROOMS)) begin
			n_active = CNT_W'(MAX_ROOMS);
		end else begin
			n_active = CNT_W'(num_rooms_q);
		end
	end

	// cell chain
	assign link[0] = head_q;
	assign tail    = link[MAX_ROOMS];

	for (genvar k = 0; k < MAX_ROOMS; k++) begin : g_cell
		assign active[k] = 32'(k) < 32'(n_active);

		ra_cell #(
			.IDX (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.active     (active[k]),
			.start_time (start_q),
			.upd        (upd),
			.scan_in    (link[k]),
			.scan_out   (link[k+1])
		);
	end

	for (genvar k = 0; k <= MAX_ROOMS; k++) begin : g_tok
		assign tok_v[k] = link[k].valid;
	end

	// free room finishes at end_time; otherwise wait for the earliest and add the duration
	assign sum       = {1'b0, tail.efin} + (ra_pkg::FINISH_W+1)'(dur_q);
	assign pick_calc = tail.found ? tail.pick : tail.earliest;
	always_comb begin
		if (tail.found) begin
			fin_calc = ra_pkg::FINISH_W'(end_q);
		end else if (sum[ra_pkg::FINISH_W]) begin
			fin_calc = '1;
		end else begin
			fin_calc = sum[ra_pkg::FINISH_W-1:0];
		end
	end

	assign out_free = !out_valid_q || res.ready;

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		launch_scan = 1'b0;
		launch_busy = 1'b0;
		take_scan   = 1'b0;
		load_out    = 1'b0;
		upd         = '0;
		unique case (state_q)
			ra_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					launch_scan = 1'b1;
					state_d     = ra_pkg::ST_SCAN;
				end
			end
			ra_pkg::ST_SCAN: begin
				// token back at the tail: commit the room this cycle
				if (tail.valid) begin
					take_scan  = 1'b1;
					upd.wr     = 1'b1;
					upd.slot   = pick_calc;
					upd.finish = fin_calc;
					if (last_q) begin
						launch_busy = 1'b1;
						state_d     = ra_pkg::ST_BUSY;
					end else begin
						state_d = ra_pkg::ST_OUT;
					end
				end
			end
			ra_pkg::ST_BUSY: begin
				if (tail.valid) begin
					state_d = ra_pkg::ST_OUT;
				end
			end
			ra_pkg::ST_OUT: begin
				// last of a set: wipe all rooms as the result leaves
				if (out_free) begin
					load_out = 1'b1;
					upd.clr  = last_q;
					state_d  = ra_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ra_pkg::ST_IDLE;
			end
		endcase
	end

	assign req.ready = req_ready;

	// token injection, a one-cycle pulse at the head of the chain
	always_comb begin
		head_d       = '0;
		head_d.valid = launch_scan || launch_busy;
		head_d.mode  = launch_busy ? ra_pkg::MODE_BUSY : ra_pkg::MODE_SCAN;
		head_d.efin  = '1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q <= head_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (launch_scan) begin
			start_q <= req.start_time;
			end_q   <= req.end_time;
			last_q  <= req.last_request;
			dur_q   <= (req.end_time > req.start_time) ? req.end_time - req.start_time : '0;
		end
	end

	// scan outcome capture
	always_ff @(posedge clk) begin
		if (take_scan) begin
			pick_q <= pick_calc;
			fin_q  <= fin_calc;
			dly_q  <= !tail.found;
		end
		if (launch_scan) begin
			busiest_q <= '0;
		end else if (state_q == ra_pkg::ST_BUSY && tail.valid) begin
			busiest_q <= tail.busiest;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_room_q <= pick_q[ra_pkg::ROOM_W-1:0];
			res_fin_q  <= fin_q;
			res_dly_q  <= dly_q;
			res_busy_q <= busiest_q[ra_pkg::ROOM_W-1:0];
			res_last_q <= last_q;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.room         = res_room_q;
	assign res.finish_time  = res_fin_q;
	assign res.was_delayed  = res_dly_q;
	assign res.busiest_room = res_busy_q;
	assign res.is_last      = res_last_q;

	// at most one token travels the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_v) <= 1)
		else $error("more than one token in the room chain");

	// a token only reaches the tail while the controller waits for it
	a_tail_state: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> (state_q == ra_pkg::ST_SCAN || state_q == ra_pkg::ST_BUSY))
		else $error("token at chain tail outside a scan");

	// the assigned room lies among the rooms in use
	a_pick_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> 32'(pick_q) < 32'(n_active))
		else $error("assigned room beyond active count");

	// a result appears only from the load state
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ra_pkg::ST_OUT)
		else $error("result raised outside load state");

endmodule

>>> rtl/ra_cell.sv
// one room cell: finish time, use count and one hop of the scan chain
module ra_cell #(
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      active,
	input  logic [ra_pkg::TIME_W-1:0] start_time,
	input  ra_pkg::upd_t              upd,
	input  ra_pkg::scan_t             scan_in,
	output ra_pkg::scan_t             scan_out
);

	localparam logic [ra_pkg::SLOT_W-1:0] MY_SLOT = ra_pkg::SLOT_W'(IDX);

	logic [ra_pkg::FINISH_W-1:0] finish_q;
	logic [ra_pkg::USES_W-1:0]   uses_q;
	ra_pkg::scan_t               nxt;
	ra_pkg::scan_t               scan_q;

	always_comb begin
		nxt = scan_in;
		if (scan_in.valid && active) begin
			unique case (scan_in.mode)
				ra_pkg::MODE_SCAN: begin
					if (!scan_in.found &&
						finish_q <= {{(ra_pkg::FINISH_W-ra_pkg::TIME_W){1'b0}}, start_time}) begin
						nxt.found = 1'b1;
						nxt.pick  = MY_SLOT;
					end
					if (finish_q < scan_in.efin) begin
						nxt.earliest = MY_SLOT;
						nxt.efin     = finish_q;
					end
				end
				ra_pkg::MODE_BUSY: begin
					if (uses_q > scan_in.best_uses) begin
						nxt.busiest   = MY_SLOT;
						nxt.best_uses = uses_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finish_q <= '0;
			uses_q   <= '0;
		end else if (upd.clr) begin
			finish_q <= '0;
			uses_q   <= '0;
		end else if (upd.wr && upd.slot == MY_SLOT) begin
			finish_q <= upd.finish;
			if (uses_q != '1) begin
				uses_q <= uses_q + 1'b1;
			end
		end
	end

	assign scan_out = scan_q;

endmodule

>>> verif/tb_room_allocator_with_delay.sv
// testbench of the room allocator: directed table and random sets
`timescale 1ns / 1ps

module tb_room_allocator_with_delay;

	// one result as the allocator reports it
	typedef struct packed {
		logic [ra_pkg::ROOM_W-1:0]   room;
		logic [ra_pkg::FINISH_W-1:0] finish;
		logic                        delayed;
		logic [ra_pkg::ROOM_W-1:0]   busiest;
		logic                        last;
	} alloc_t;

	// one row of the directed table; cfg of -1 leaves the room count alone
	typedef struct {
		int                          cfg;
		logic [ra_pkg::TIME_W-1:0]   start_t;
		logic [ra_pkg::TIME_W-1:0]   end_t;
		logic                        last;
		bit                          typed;
		logic [ra_pkg::ROOM_W-1:0]   room;
		logic [ra_pkg::FINISH_W-1:0] finish;
		logic                        delayed;
		logic [ra_pkg::ROOM_W-1:0]   busiest;
	} dir_row_t;

	localparam int                          DIR_ROWS      = 21;
	localparam int                          RAND_ITEMS    = 1100;
	localparam int                          STALL_LIMIT   = 1000;
	localparam int                          SETTLE_CYCLES = 2 * ra_pkg::MAX_ROOMS_DEF + 8;
	localparam logic [ra_pkg::FINISH_W-1:0] FINISH_SAT    = {ra_pkg::FINISH_W{1'b1}};
	localparam logic [ra_pkg::USES_W-1:0]   USES_SAT      = {ra_pkg::USES_W{1'b1}};

	logic clk;
	logic arst_n;

	ra_req_if req_ch ();
	ra_res_if res_ch ();
	ra_cfg_if cfg_ch ();

	room_allocator_with_delay u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// own copy of the room state and of the room count register
	logic [ra_pkg::FINISH_W-1:0] finish_tab [ra_pkg::MAX_ROOMS_DEF];
	logic [ra_pkg::USES_W-1:0]   uses_tab [ra_pkg::MAX_ROOMS_DEF];
	logic [ra_pkg::CFG_W-1:0]    room_count_q;

	// results still owed by the allocator, oldest first
	alloc_t   pending_allocs [$];
	dir_row_t dir_rows [DIR_ROWS];
	int       mismatches  = 0;
	int       idle_cycles = 0;
	// no idling on either side while set
	bit       steady      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// out-of-range counts fold back to 1 or to the full set of rooms
	function automatic int active_room_count(input logic [ra_pkg::CFG_W-1:0] count);
		if (count == '0)
			return 1;
		if (count > ra_pkg::CFG_W'(ra_pkg::MAX_ROOMS_DEF))
			return ra_pkg::MAX_ROOMS_DEF;
		return int'(count);
	endfunction

	// lowest free room, else the earliest finisher; updates the rooms as it goes
	function automatic alloc_t predict_allocation(input logic [ra_pkg::TIME_W-1:0] start_t,
		input logic [ra_pkg::TIME_W-1:0] end_t, input logic last);
		alloc_t                      res;
		int                          n;
		int                          pick;
		int                          earliest;
		int                          busiest;
		bit                          found;
		logic [ra_pkg::TIME_W-1:0]   dur;
		logic [ra_pkg::FINISH_W:0]   sum;
		logic [ra_pkg::FINISH_W-1:0] fin;

		n        = active_room_count(room_count_q);
		pick     = 0;
		earliest = 0;
		busiest  = 0;
		found    = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (!found && finish_tab[i] <= ra_pkg::FINISH_W'(start_t)) begin
				found = 1'b1;
				pick  = i;
			end
			if (finish_tab[i] < finish_tab[earliest])
				earliest = i;
		end
		// end not after start counts as zero duration
		dur = (end_t > start_t) ? end_t - start_t : '0;
		if (found) begin
			fin = ra_pkg::FINISH_W'(end_t);
		end else begin
			pick = earliest;
			sum  = {1'b0, finish_tab[earliest]} + (ra_pkg::FINISH_W + 1)'(dur);
			fin  = (sum > {1'b0, FINISH_SAT}) ? FINISH_SAT : sum[ra_pkg::FINISH_W-1:0];
		end
		finish_tab[pick] = fin;
		if (uses_tab[pick] != USES_SAT)
			uses_tab[pick] = uses_tab[pick] + 1'b1;
		if (last) begin
			for (int i = 1; i < n; i++)
				if (uses_tab[i] > uses_tab[busiest])
					busiest = i;
		end
		res.room    = ra_pkg::ROOM_W'(pick);
		res.finish  = fin;
		res.delayed = !found;
		res.busiest = last ? ra_pkg::ROOM_W'(busiest) : '0;
		res.last    = last;
		// the last request of a set leaves every room empty
		if (last) begin
			foreach (finish_tab[i]) begin
				finish_tab[i] = '0;
				uses_tab[i]   = '0;
			end
		end
		return res;
	endfunction

	// mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(21, 60);
	endfunction

	// offer one request; valid stays high after acceptance so back-to-back requests run
	task automatic send_request(input logic [ra_pkg::TIME_W-1:0] start_t,
		input logic [ra_pkg::TIME_W-1:0] end_t, input logic last, input int gap,
		input bit typed, input alloc_t want);
		alloc_t got;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.start_time   <= start_t;
		req_ch.end_time     <= end_t;
		req_ch.last_request <= last;
		do @(posedge clk); while (!req_ch.ready);
		got = predict_allocation(start_t, end_t, last);
		// typed rows keep their hand-written result, the predictor still moves the state
		pending_allocs.push_back(typed ? want : got);
	endtask

	// the room count is only changed once every owed result is back
	task automatic write_room_count(input logic [ra_pkg::CFG_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (pending_allocs.size() != 0) @(posedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.num_rooms <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		room_count_q = value;
		cfg_ch.valid <= 1'b0;
	endtask

	// result side: random back-pressure and the comparison against the oldest owed result
	initial begin
		alloc_t act;
		alloc_t exp_res;
		int     stall;

		stall = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				act.room    = res_ch.room;
				act.finish  = res_ch.finish_time;
				act.delayed = res_ch.was_delayed;
				act.busiest = res_ch.busiest_room;
				act.last    = res_ch.is_last;
				if (pending_allocs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with no request owed: room %0d finish %0h", act.room,
							act.finish);
				end else begin
					exp_res = pending_allocs.pop_front();
					if (act !== exp_res) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp room %0d finish %0h delayed %0b busiest %0d ",
								"last %0b, got room %0d finish %0h delayed %0b busiest %0d last %0b"},
								exp_res.room, exp_res.finish, exp_res.delayed, exp_res.busiest,
								exp_res.last, act.room, act.finish, act.delayed, act.busiest,
								act.last);
					end
				end
			end
			// stall for a random stretch after each ready cycle
			if (steady || stall == 0) begin
				res_ch.ready <= 1'b1;
				stall = pick_gap();
			end else begin
				res_ch.ready <= 1'b0;
				stall--;
			end
		end
	end

	// watchdog: too many cycles without any handshake ends the run
	initial begin
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		alloc_t                    want;
		logic [ra_pkg::TIME_W-1:0] t;
		logic [ra_pkg::TIME_W-1:0] s;
		logic [ra_pkg::TIME_W-1:0] e;
		logic [ra_pkg::CFG_W-1:0]  rc;
		int                        sent;
		int                        set_len;
		int                        span;
		int                        n;
		int                        r;

		// cfg, start, end, last, typed, room, finish, delayed, busiest
		dir_rows = '{
			// reset room count: lowest free room, zero duration, widest end, end before start
			'{-1, 0, 100, 0, 1, 0, 100, 0, 0},
			'{-1, 0, 0, 0, 1, 1, 0, 0, 0},
			'{-1, 0, 32'hFFFF_FFFF, 0, 1, 1, 48'hFFFF_FFFF, 0, 0},
			'{-1, 10, 5, 0, 1, 2, 5, 0, 0},
			'{-1, 20, 30, 1, 1, 2, 30, 0, 1},
			// single room: waits, a waiting request of zero duration
			'{1, 0, 10, 0, 1, 0, 10, 0, 0},
			'{-1, 5, 8, 0, 1, 0, 13, 1, 0},
			'{-1, 5, 5, 0, 1, 0, 13, 1, 0},
			'{-1, 20, 15, 1, 1, 0, 15, 0, 0},
			// a count of zero behaves as one room
			'{0, 0, 50, 0, 1, 0, 50, 0, 0},
			'{-1, 1, 2, 1, 1, 0, 51, 1, 0},
			// two rooms: earliest finisher, tie goes to the lower room, busiest room
			'{2, 0, 40, 0, 1, 0, 40, 0, 0},
			'{-1, 0, 30, 0, 1, 1, 30, 0, 0},
			'{-1, 10, 20, 0, 1, 1, 40, 1, 0},
			'{-1, 10, 15, 0, 1, 0, 45, 1, 0},
			'{-1, 40, 41, 1, 1, 1, 41, 0, 1},
			// count above the top, largest start
			'{31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0, 48'hFFFF_FFFF, 0, 0},
			'{-1, 32'hFFFF_FFFF, 0, 1, 1, 0, 0, 0, 0},
			// full room count written back, left to the predictor
			'{16, 7, 3000, 0, 0, 0, 0, 0, 0},
			'{-1, 8, 9, 0, 0, 0, 0, 0, 0},
			'{-1, 8, 8, 1, 0, 0, 0, 0, 0}
		};

		foreach (finish_tab[i]) begin
			finish_tab[i] = '0;
			uses_tab[i]   = '0;
		end
		room_count_q = ra_pkg::NUM_ROOMS_RST;

		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.start_time   <= '0;
		req_ch.end_time     <= '0;
		req_ch.last_request <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.num_rooms    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[k]) begin
			if (dir_rows[k].cfg >= 0)
				write_room_count(ra_pkg::CFG_W'(dir_rows[k].cfg));
			want.room    = dir_rows[k].room;
			want.finish  = dir_rows[k].finish;
			want.delayed = dir_rows[k].delayed;
			want.busiest = dir_rows[k].busiest;
			want.last    = dir_rows[k].last;
			send_request(dir_rows[k].start_t, dir_rows[k].end_t, dir_rows[k].last, pick_gap(),
				dir_rows[k].typed, want);
		end

		// random sets: mostly ordered starts with overlapping durations, some noise
		sent = 0;
		while (sent < RAND_ITEMS) begin
			steady = ($urandom_range(0, 6) == 0);
			if (sent == 0 || $urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 9))
					0: rc = ra_pkg::CFG_W'(0);
					1: rc = ra_pkg::CFG_W'(1);
					2: rc = ra_pkg::CFG_W'(16);
					3: rc = ra_pkg::CFG_W'($urandom_range(17, 31));
					default: rc = ra_pkg::CFG_W'($urandom_range(2, 15));
				endcase
				write_room_count(rc);
			end
			n       = active_room_count(room_count_q);
			set_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 80);
			// duration spread sized to the room count so sets both wait and find free rooms
			span    = $urandom_range(1, 10 * n);
			t       = ($urandom_range(0, 3) == 0) ? $urandom :
				ra_pkg::TIME_W'($urandom_range(0, 1000));
			for (int j = 0; j < set_len; j++) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					// start order broken
					s = $urandom;
				end else begin
					t = t + ra_pkg::TIME_W'($urandom_range(0, 6));
					s = t;
				end
				if (r >= 4 && r < 8)
					e = s - ra_pkg::TIME_W'($urandom_range(0, 100));
				else if (r < 11)
					e = $urandom;
				else
					e = s + ra_pkg::TIME_W'($urandom_range(1, span));
				send_request(s, e, j == set_len - 1, pick_gap(), 1'b0, '0);
				sent++;
			end
		end
		steady = 1'b0;

		// drain, then give the allocator time to show any stray result
		req_ch.valid <= 1'b0;
		while (pending_allocs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
